### src/dteq_pkg.sv
// Shared constants for the delta-timed event queue.
// Field widths, slot encoding and function codes; no dependencies.
`timescale 1ns / 1ps

package dteq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int TYPE_W = 8;
  localparam int WORD_W = 32;
  localparam int DLY_W  = 16;

  // A delay slot holds a free flag above the remaining delay.
  localparam int SLOT_W = DLY_W + 1;

  // A payload entry holds the type code and three words.
  localparam int PAY_W = TYPE_W + 3 * WORD_W;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

endpackage

### src/dteq_ram.sv
// Generic simple dual-port RAM with a registered read port.
// One write port and one read port with read enable; no dependencies.
`timescale 1ns / 1ps

module dteq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/delta_timed_event_queue.sv
// Delta-timed event queue: an insert reads the slot after the write pointer and then the one
// before the pointer, then writes both RAMs; it is dropped when the ring is full. A tick with
// nothing pending leaves the block idle; otherwise each released event takes a delay read, a
// payload read and a hand-off to the output register, which waits while the output stalls;
// the single read ports keep these steps serial. After reset a clearing pass marks every
// slot free, with in_stall_o held high; pointers and flags clear at once.
`timescale 1ns / 1ps

module delta_timed_event_queue #(
  parameter int QUEUE_DEPTH = dteq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [dteq_pkg::TYPE_W-1:0] event_type_i,
  input  logic [dteq_pkg::WORD_W-1:0] value_one_i,
  input  logic [dteq_pkg::WORD_W-1:0] value_two_i,
  input  logic [dteq_pkg::WORD_W-1:0] value_three_i,
  input  logic [dteq_pkg::DLY_W-1:0]  delay_frames_i,

  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [dteq_pkg::TYPE_W-1:0] out_type_o,
  output logic [dteq_pkg::WORD_W-1:0] out_value_one_o,
  output logic [dteq_pkg::WORD_W-1:0] out_value_two_o,
  output logic [dteq_pkg::WORD_W-1:0] out_value_three_o,
  output logic                        last_in_run_o
);

  localparam int TYPE_W = dteq_pkg::TYPE_W;
  localparam int WORD_W = dteq_pkg::WORD_W;
  localparam int DLY_W  = dteq_pkg::DLY_W;
  localparam int SLOT_W = dteq_pkg::SLOT_W;
  localparam int PAY_W  = dteq_pkg::PAY_W;
  localparam int AW     = $clog2(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

  localparam logic [2:0] ST_CLR      = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_INS_A    = 3'd2;
  localparam logic [2:0] ST_INS_B    = 3'd3;
  localparam logic [2:0] ST_TK_RD    = 3'd4;
  localparam logic [2:0] ST_TK_FLUSH = 3'd5;
  localparam logic [2:0] ST_TK_PAY   = 3'd6;

  localparam logic [SLOT_W-1:0] SLOT_FREE = {1'b1, {DLY_W{1'b0}}};

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] wr_idx_q, wr_idx_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] clr_idx_q, clr_idx_d;
  logic          has_pend_q, has_pend_d;
  logic          stop_q, stop_d;
  logic          hold_valid_q, hold_valid_d;
  logic          out_valid_q, out_valid_d;

  logic [TYPE_W-1:0] ins_type_q;
  logic [WORD_W-1:0] ins_one_q, ins_two_q, ins_three_q;
  logic [DLY_W-1:0]  ins_dly_q;
  logic [PAY_W-1:0]  hold_q;
  logic [PAY_W-1:0]  out_pay_q;
  logic              out_last_q;

  logic              in_accept;
  logic              out_load;

  logic              d_we, d_re;
  logic [AW-1:0]     d_waddr, d_raddr;
  logic [SLOT_W-1:0] d_wdata, d_rdata;
  logic              d_free;
  logic [DLY_W-1:0]  d_val;
  logic [DLY_W-1:0]  ins_val;

  logic              p_we, p_re;
  logic [PAY_W-1:0]  p_wdata, p_rdata;

  logic [AW-1:0]     wr_next, wr_prev, rd_next;

  assign wr_next = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + AW'(1);
  assign wr_prev = (wr_idx_q == '0) ? LAST_IDX : wr_idx_q - AW'(1);
  assign rd_next = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + AW'(1);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_TK_FLUSH) && hold_valid_q &&
                      (!out_valid_q || !out_stall_i);

  assign d_free = d_rdata[SLOT_W-1];
  assign d_val  = d_rdata[DLY_W-1:0];

  // A pending predecessor turns the new delay into a distance from its remaining delay.
  assign ins_val = d_free ? ins_dly_q :
                   (ins_dly_q < d_val) ? (d_val - ins_dly_q) : (ins_dly_q - d_val);

  assign p_we    = (state_q == ST_INS_B);
  assign p_wdata = {ins_type_q, ins_one_q, ins_two_q, ins_three_q};
  assign p_re    = (state_q == ST_TK_RD) && !d_free && (d_val == '0);

  always_comb begin
    d_we    = 1'b0;
    d_waddr = rd_idx_q;
    d_wdata = SLOT_FREE;
    d_re    = 1'b0;
    d_raddr = rd_idx_q;
    unique case (state_q)
      ST_CLR: begin
        d_we    = 1'b1;
        d_waddr = clr_idx_q;
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (func_i == dteq_pkg::FUNC_INSERT) begin
            d_re    = 1'b1;
            d_raddr = wr_next;
          end else begin
            d_re = has_pend_q;
          end
        end
      end
      ST_INS_A: begin
        d_re    = d_free;
        d_raddr = wr_prev;
      end
      ST_INS_B: begin
        d_we    = 1'b1;
        d_waddr = wr_idx_q;
        d_wdata = {1'b0, ins_val};
      end
      ST_TK_RD: begin
        d_we    = !d_free;
        d_wdata = (d_val == '0) ? SLOT_FREE : {1'b0, d_val - DLY_W'(1)};
      end
      ST_TK_PAY: begin
        d_re = (cnt_q != LAST_IDX);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    wr_idx_d     = wr_idx_q;
    rd_idx_d     = rd_idx_q;
    cnt_d        = cnt_q;
    clr_idx_d    = clr_idx_q;
    has_pend_d   = has_pend_q;
    stop_d       = stop_q;
    hold_valid_d = hold_valid_q;
    out_valid_d  = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
    unique case (state_q)
      ST_CLR: begin
        clr_idx_d = clr_idx_q + AW'(1);
        if (clr_idx_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (func_i == dteq_pkg::FUNC_INSERT) begin
            has_pend_d = 1'b1;
            state_d    = ST_INS_A;
          end else if (has_pend_q) begin
            cnt_d   = '0;
            state_d = ST_TK_RD;
          end
        end
      end
      ST_INS_A: begin
        // An occupied slot after the write pointer means the ring is full.
        state_d = d_free ? ST_INS_B : ST_IDLE;
      end
      ST_INS_B: begin
        wr_idx_d = wr_next;
        state_d  = ST_IDLE;
      end
      ST_TK_RD: begin
        if (!d_free && (d_val == '0)) begin
          rd_idx_d = rd_next;
          cnt_d    = cnt_q + AW'(1);
          stop_d   = 1'b0;
          state_d  = hold_valid_q ? ST_TK_FLUSH : ST_TK_PAY;
        end else begin
          if (d_free) begin
            has_pend_d = 1'b0;
          end
          stop_d  = 1'b1;
          state_d = hold_valid_q ? ST_TK_FLUSH : ST_IDLE;
        end
      end
      ST_TK_FLUSH: begin
        if (out_load) begin
          hold_valid_d = 1'b0;
          state_d      = stop_q ? ST_IDLE : ST_TK_PAY;
        end
      end
      ST_TK_PAY: begin
        hold_valid_d = 1'b1;
        if (cnt_q == LAST_IDX) begin
          stop_d  = 1'b1;
          state_d = ST_TK_FLUSH;
        end else begin
          state_d = ST_TK_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      wr_idx_q     <= '0;
      rd_idx_q     <= '0;
      cnt_q        <= '0;
      clr_idx_q    <= '0;
      has_pend_q   <= 1'b0;
      stop_q       <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      wr_idx_q     <= wr_idx_d;
      rd_idx_q     <= rd_idx_d;
      cnt_q        <= cnt_d;
      clr_idx_q    <= clr_idx_d;
      has_pend_q   <= has_pend_d;
      stop_q       <= stop_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ins_type_q  <= event_type_i;
      ins_one_q   <= value_one_i;
      ins_two_q   <= value_two_i;
      ins_three_q <= value_three_i;
      ins_dly_q   <= delay_frames_i;
    end
    if (state_q == ST_TK_PAY) begin
      hold_q <= p_rdata;
    end
    if (out_load) begin
      out_pay_q  <= hold_q;
      out_last_q <= stop_q;
    end
  end

  dteq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .re_i    (d_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  dteq_ram #(
    .WIDTH (PAY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (wr_idx_q),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (rd_idx_q),
    .rdata_o (p_rdata)
  );

  assign out_valid_o       = out_valid_q;
  assign out_type_o        = out_pay_q[PAY_W-1 -: TYPE_W];
  assign out_value_one_o   = out_pay_q[3*WORD_W-1 -: WORD_W];
  assign out_value_two_o   = out_pay_q[2*WORD_W-1 -: WORD_W];
  assign out_value_three_o = out_pay_q[WORD_W-1:0];
  assign last_in_run_o     = out_last_q;

  // Every held release must have been handed on before the block takes a new item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !hold_valid_q)
    else $error("held release left behind at idle");

  // The final release of a run reaches the output with its last flag set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && stop_q) |=> (out_valid_o && last_in_run_o))
    else $error("final release not flagged as last");

  // The write pointer moves only when an insert commits its slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_INS_B) |=> $stable(wr_idx_q))
    else $error("write pointer moved outside an insert");

  // Releases within one tick never exceed the ring depth less one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TK_RD) |-> (cnt_q != LAST_IDX))
    else $error("tick continued past the release bound");

endmodule

### sim/delta_timed_event_queue_tb.sv
// Self-checking testbench for delta_timed_event_queue: directed, full-ring and random phases,
// with a scoreboard that predicts every released event. Depends on dteq_pkg and the RTL.
`timescale 1ns / 1ps

typedef struct packed {
  logic                        func;
  logic [dteq_pkg::TYPE_W-1:0] event_type;
  logic [dteq_pkg::WORD_W-1:0] value_one;
  logic [dteq_pkg::WORD_W-1:0] value_two;
  logic [dteq_pkg::WORD_W-1:0] value_three;
  logic [dteq_pkg::DLY_W-1:0]  delay_frames;
} queue_cmd_t;

typedef struct packed {
  logic [dteq_pkg::TYPE_W-1:0] ev_type;
  logic [dteq_pkg::WORD_W-1:0] word_one;
  logic [dteq_pkg::WORD_W-1:0] word_two;
  logic [dteq_pkg::WORD_W-1:0] word_three;
  logic                        last_in_run;
} released_event_t;

class release_tracker;
  logic signed [dteq_pkg::SLOT_W-1:0] frames_left [dteq_pkg::QUEUE_DEPTH_DEF];
  logic [dteq_pkg::TYPE_W-1:0]        slot_kind   [dteq_pkg::QUEUE_DEPTH_DEF];
  logic [dteq_pkg::WORD_W-1:0]        slot_one    [dteq_pkg::QUEUE_DEPTH_DEF];
  logic [dteq_pkg::WORD_W-1:0]        slot_two    [dteq_pkg::QUEUE_DEPTH_DEF];
  logic [dteq_pkg::WORD_W-1:0]        slot_three  [dteq_pkg::QUEUE_DEPTH_DEF];
  int unsigned                        wr_slot;
  int unsigned                        rd_slot;
  bit                                 counting;
  released_event_t                    releases_due [$];
  int unsigned                        mismatches;

  function new();
    for (int i = 0; i < dteq_pkg::QUEUE_DEPTH_DEF; i++) frames_left[i] = '1;
    wr_slot    = 0;
    rd_slot    = 0;
    counting   = 1'b0;
    mismatches = 0;
  endfunction

  // Updates the ring for one accepted transaction and queues the events it releases.
  function void note_item(queue_cmd_t cmd);
    int unsigned                        prv;
    int unsigned                        nxt;
    int unsigned                        r;
    int                                 released;
    logic signed [dteq_pkg::SLOT_W-1:0] want_dly;
    logic signed [dteq_pkg::SLOT_W-1:0] prior;
    released_event_t                    ev;
    if (cmd.func == dteq_pkg::FUNC_INSERT) begin
      prv = (wr_slot == 0) ? dteq_pkg::QUEUE_DEPTH_DEF - 1 : wr_slot - 1;
      nxt = (wr_slot + 1) % dteq_pkg::QUEUE_DEPTH_DEF;
      // Even a dropped insert arms the countdown.
      counting = 1'b1;
      if (frames_left[nxt] < 0) begin
        want_dly = {1'b0, cmd.delay_frames};
        prior    = frames_left[prv];
        if (prior >= 0) begin
          want_dly = (want_dly < prior) ? prior - want_dly : want_dly - prior;
        end
        frames_left[wr_slot] = want_dly;
        slot_kind[wr_slot]   = cmd.event_type;
        slot_one[wr_slot]    = cmd.value_one;
        slot_two[wr_slot]    = cmd.value_two;
        slot_three[wr_slot]  = cmd.value_three;
        wr_slot              = nxt;
      end
    end else begin
      released = 0;
      while (counting && released < dteq_pkg::QUEUE_DEPTH_DEF - 1) begin
        r = rd_slot;
        if (frames_left[r] < 0) begin
          counting = 1'b0;
          break;
        end
        frames_left[r] = frames_left[r] - dteq_pkg::SLOT_W'(1);
        if (frames_left[r] >= 0) break;
        ev.ev_type     = slot_kind[r];
        ev.word_one    = slot_one[r];
        ev.word_two    = slot_two[r];
        ev.word_three  = slot_three[r];
        ev.last_in_run = 1'b0;
        releases_due.push_back(ev);
        released++;
        rd_slot = (r + 1) % dteq_pkg::QUEUE_DEPTH_DEF;
      end
      if (released > 0) begin
        ev = releases_due.pop_back();
        ev.last_in_run = 1'b1;
        releases_due.push_back(ev);
      end
    end
  endfunction

  function void check_release(released_event_t got);
    released_event_t want;
    if (releases_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 50) begin
        $display("%0t: release with nothing expected, expected none actual %h", $time, got);
      end
      return;
    end
    want = releases_due.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 50) begin
        if (got.ev_type !== want.ev_type)
          $display("%0t: out_type expected %h actual %h", $time, want.ev_type, got.ev_type);
        if (got.word_one !== want.word_one)
          $display("%0t: out_value_one expected %h actual %h", $time, want.word_one,
                   got.word_one);
        if (got.word_two !== want.word_two)
          $display("%0t: out_value_two expected %h actual %h", $time, want.word_two,
                   got.word_two);
        if (got.word_three !== want.word_three)
          $display("%0t: out_value_three expected %h actual %h", $time, want.word_three,
                   got.word_three);
        if (got.last_in_run !== want.last_in_run)
          $display("%0t: last_in_run expected %b actual %b", $time, want.last_in_run,
                   got.last_in_run);
      end
    end
  endfunction

  function int unsigned outstanding();
    return releases_due.size();
  endfunction

  // Pending slots run contiguously from the read slot, so a free read slot means an empty ring.
  function bit holds_events();
    return frames_left[rd_slot] >= 0;
  endfunction
endclass

module delta_timed_event_queue_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_ITEMS    = 85;
  localparam int TYPE_W         = dteq_pkg::TYPE_W;
  localparam int WORD_W         = dteq_pkg::WORD_W;
  localparam int DLY_W          = dteq_pkg::DLY_W;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              func_i        = dteq_pkg::FUNC_INSERT;
  logic [TYPE_W-1:0] event_type_i  = '0;
  logic [WORD_W-1:0] value_one_i   = '0;
  logic [WORD_W-1:0] value_two_i   = '0;
  logic [WORD_W-1:0] value_three_i = '0;
  logic [DLY_W-1:0]  delay_frames_i = '0;
  logic              out_stall_i   = 1'b0;

  logic              in_stall_o;
  logic              out_valid_o;
  logic [TYPE_W-1:0] out_type_o;
  logic [WORD_W-1:0] out_value_one_o;
  logic [WORD_W-1:0] out_value_two_o;
  logic [WORD_W-1:0] out_value_three_o;
  logic              last_in_run_o;

  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       quiet_cycles   = 0;
  released_event_t   seen_event;
  release_tracker    tracker;

  delta_timed_event_queue uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .event_type_i     (event_type_i),
    .value_one_i      (value_one_i),
    .value_two_i      (value_two_i),
    .value_three_i    (value_three_i),
    .delay_frames_i   (delay_frames_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_type_o       (out_type_o),
    .out_value_one_o  (out_value_one_o),
    .out_value_two_o  (out_value_two_o),
    .out_value_three_o(out_value_three_o),
    .last_in_run_o    (last_in_run_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_event.ev_type     = out_type_o;
      seen_event.word_one    = out_value_one_o;
      seen_event.word_two    = out_value_two_o;
      seen_event.word_three  = out_value_three_o;
      seen_event.last_in_run = last_in_run_o;
      tracker.check_release(seen_event);
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL delta_timed_event_queue");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic queue_cmd_t make_cmd(logic op, logic [DLY_W-1:0] dly);
    queue_cmd_t cmd;
    cmd.func         = op;
    cmd.event_type   = TYPE_W'($urandom);
    cmd.value_one    = $urandom;
    cmd.value_two    = $urandom;
    cmd.value_three  = $urandom;
    // A tick ignores the delay, so it carries noise there.
    cmd.delay_frames = (op == dteq_pkg::FUNC_TICK) ? DLY_W'($urandom) : dly;
    return cmd;
  endfunction

  task automatic send_cmd(queue_cmd_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= cmd.func;
    event_type_i   <= cmd.event_type;
    value_one_i    <= cmd.value_one;
    value_two_i    <= cmd.value_two;
    value_three_i  <= cmd.value_three;
    delay_frames_i <= cmd.delay_frames;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_item(cmd);
  endtask

  task automatic tick_until_empty();
    while (tracker.holds_events()) send_cmd(make_cmd(dteq_pkg::FUNC_TICK, '0));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.outstanding() != 0);
  endtask

  initial begin
    queue_cmd_t  cmd;
    int unsigned sent;
    int unsigned burst;
    tracker = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: tick on an empty ring, zero delay, all-zero and all-one payloads,
    // relative delays below, above and equal to the predecessor, and a multi-event run.
    send_cmd(make_cmd(dteq_pkg::FUNC_TICK, '0));
    cmd = make_cmd(dteq_pkg::FUNC_INSERT, '0);
    cmd.event_type  = '0;
    cmd.value_one   = '0;
    cmd.value_two   = '0;
    cmd.value_three = '0;
    send_cmd(cmd);
    send_cmd(make_cmd(dteq_pkg::FUNC_TICK, '0));
    send_cmd(make_cmd(dteq_pkg::FUNC_TICK, '0));
    cmd = make_cmd(dteq_pkg::FUNC_INSERT, DLY_W'(3));
    cmd.event_type  = '1;
    cmd.value_one   = '1;
    cmd.value_two   = '1;
    cmd.value_three = '1;
    send_cmd(cmd);
    send_cmd(make_cmd(dteq_pkg::FUNC_INSERT, DLY_W'(5)));
    send_cmd(make_cmd(dteq_pkg::FUNC_INSERT, DLY_W'(1)));
    send_cmd(make_cmd(dteq_pkg::FUNC_INSERT, DLY_W'(1)));
    repeat (8) send_cmd(make_cmd(dteq_pkg::FUNC_TICK, '0));
    wait_drained();

    // Full ring: the head waits out a delay, the rest trail at zero distance,
    // further inserts are dropped, and one tick finally releases the whole ring.
    recv_stall_pct = 58;
    tick_until_empty();
    send_cmd(make_cmd(dteq_pkg::FUNC_INSERT, DLY_W'(20)));
    send_cmd(make_cmd(dteq_pkg::FUNC_INSERT, DLY_W'(20)));
    repeat (dteq_pkg::QUEUE_DEPTH_DEF - 3) send_cmd(make_cmd(dteq_pkg::FUNC_INSERT, '0));
    repeat (3) send_cmd(make_cmd(dteq_pkg::FUNC_INSERT, DLY_W'($urandom)));
    tick_until_empty();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: begin
          send_idle_pct  = 58;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 58;
        end
        3: begin
          send_idle_pct  = 11;
          recv_stall_pct = 11;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // A burst of inserts with mostly short delays, then a run of ticks to count them down.
        burst = $urandom_range(4);
        repeat (burst) begin
          if ($urandom_range(9) < 7) begin
            send_cmd(make_cmd(dteq_pkg::FUNC_INSERT, DLY_W'($urandom_range(3))));
          end else begin
            send_cmd(make_cmd(dteq_pkg::FUNC_INSERT, DLY_W'($urandom_range(24))));
          end
        end
        sent += burst;
        burst = $urandom_range(6, 1);
        repeat (burst) send_cmd(make_cmd(dteq_pkg::FUNC_TICK, '0));
        sent += burst;
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("PASS delta_timed_event_queue");
    end else begin
      $display("FAIL delta_timed_event_queue");
    end
    $finish;
  end

endmodule
